>>> hdl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/ascp_pkg.sv
// Package with types, constants and helpers of the audio config parser.
package ascp_pkg;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ShiftW = 24;
  localparam int unsigned CntW = 5;
  localparam int unsigned LoopW = 8;
  localparam int unsigned NumGroups = 6;

  localparam logic [4:0] AotEscape = 5'd31;
  localparam logic [3:0] SfiExplicit = 4'hf;
  localparam logic [6:0] AotSbr = 7'd5;
  localparam logic [6:0] AotPs = 7'd29;
  localparam logic [6:0] AotErBsac = 7'd22;
  localparam logic [6:0] AotGaMax = 7'd23;
  localparam logic [4:0] DelayBits = 5'd14;
  localparam logic [4:0] RateBits = 5'd24;

  typedef enum logic [5:0] {
    PH_IDLE, PH_DONE, PH_AOT1, PH_AOT1X, PH_SFI, PH_RATE, PH_CH,
    PH_ESFI, PH_ERATE, PH_AOT2, PH_AOT2X, PH_ECH,
    PH_FLF, PH_DCC, PH_DELAY, PH_EXTF,
    PH_PCEHEAD, PH_CNT0, PH_CNT1, PH_CNT2, PH_CNT3, PH_CNT4, PH_CNT5,
    PH_MONO, PH_MONON, PH_STEREO, PH_STEREON, PH_MATRIX, PH_MATRIXV,
    PH_EL0, PH_EL1, PH_EL2, PH_EL3, PH_EL4, PH_EL5,
    PH_ALIGN, PH_CLEN, PH_CBYTE, PH_LAYER, PH_SUBF, PH_RES, PH_EXT3
  } phase_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;       // new descriptor: clear fields
    logic shift_bit;   // shift one bit in, count it
    logic load_field;  // start a new field
    logic [CntW-1:0] field_len;
    logic set_aot;     // h_aot <= value (or 32 + value when escaped)
    logic aot_escaped;
    logic set_ext;
    logic set_sfi;
    logic set_rate;
    logic set_ch;
    logic set_esfi;
    logic set_dcc;
    logic set_extf;
    logic set_count;   // element_counts[count_idx] <= value
    logic [2:0] count_idx;
    logic load_loop;   // loop_remaining <= loop_value
    logic [LoopW-1:0] loop_value;
    logic dec_loop;
  } cmd_t;

  // Datapath status.
  typedef struct packed {
    logic field_done;           // the bit being shifted ends its field
    logic [ShiftW-1:0] value;   // field value including the current bit
    logic [2:0] bit_pos;        // bits of the byte consumed, after this bit
    logic [6:0] aot;
    logic [3:0] ch;
    logic dcc;
    logic extf;
    logic [LoopW-1:0] loop_left;
    logic [NumGroups-1:0] count_nz;
    logic [NumGroups-1:0][3:0] counts;
  } stat_t;

  function automatic logic [CntW-1:0] cnt_width(input logic [2:0] k);
    unique case (k)
      3'd3: cnt_width = 5'd2;
      3'd4: cnt_width = 5'd3;
      default: cnt_width = 5'd4;
    endcase
  endfunction

  function automatic logic [CntW-1:0] el_width(input logic [2:0] k);
    unique case (k)
      3'd3, 3'd4: el_width = 5'd4;
      default: el_width = 5'd5;
    endcase
  endfunction
endpackage

>>> hdl/ascp_if.sv
// Valid/ready channel interfaces for input bytes and parse results.
interface ascp_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic start_req;
  logic last_byte;
  modport source (output valid, data_byte, start_req, last_byte, input ready);
  modport sink (input valid, data_byte, start_req, last_byte, output ready);
endinterface

interface ascp_out_if (input logic clk);
  logic valid;
  logic ready;
  logic status;
  logic [6:0] core_aot;
  logic [6:0] extension_type;
  logic [3:0] sampling_index;
  logic [23:0] sampling_rate;
  logic [3:0] ext_sampling_index;
  logic [3:0] channel_config;
  modport source (output valid, status, core_aot, extension_type, sampling_index,
                  sampling_rate, ext_sampling_index, channel_config, input ready);
  modport sink (input valid, status, core_aot, extension_type, sampling_index,
                sampling_rate, ext_sampling_index, channel_config, output ready);
endinterface

>>> hdl/ascp_datapath.sv
// Bit shifter, field counters, held fields and element counts.
module ascp_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] byte_reg,
  input  logic [2:0] bit_idx,
  input  ascp_pkg::cmd_t cmd,
  output ascp_pkg::stat_t stat,
  output logic [6:0] h_aot,
  output logic [6:0] h_ext,
  output logic [3:0] h_sfi,
  output logic [23:0] h_rate,
  output logic [3:0] h_esfi,
  output logic [3:0] h_ch
);
  import ascp_pkg::*;

  logic [ShiftW-1:0] field_shift;
  logic [CntW-1:0] field_bits_left;
  logic [LoopW-1:0] loop_remaining;
  logic [3:0] element_counts [NumGroups];
  logic [1:0] gas_flags;
  logic cur_bit;
  logic [ShiftW-1:0] shifted;
  logic [CntW-1:0] left_dec;

  assign cur_bit = byte_reg[3'd7 - bit_idx];
  assign shifted = {field_shift[ShiftW-2:0], cur_bit};
  assign left_dec = (field_bits_left != '0) ? field_bits_left - 1'b1 : '0;

  always_comb begin
    stat.field_done = (left_dec == '0);
    stat.value = shifted;
    stat.bit_pos = bit_idx + 3'd1;
    stat.aot = h_aot;
    stat.ch = h_ch;
    stat.dcc = gas_flags[0];
    stat.extf = gas_flags[1];
    stat.loop_left = loop_remaining;
    for (int k = 0; k < NumGroups; k++) begin
      stat.count_nz[k] = (element_counts[k] != 4'd0);
      stat.counts[k] = element_counts[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      field_shift <= '0;
      field_bits_left <= '0;
      loop_remaining <= '0;
      gas_flags <= '0;
      h_aot <= '0; h_ext <= '0; h_sfi <= '0; h_rate <= '0; h_esfi <= '0; h_ch <= '0;
      if (cmd.clear) begin
        field_bits_left <= cmd.field_len;
      end
    end else begin
      if (cmd.shift_bit) begin
        field_shift <= shifted;
        field_bits_left <= left_dec;
      end
      if (cmd.load_field) begin
        field_shift <= '0;
        field_bits_left <= cmd.field_len;
      end
      if (cmd.set_aot) begin
        h_aot <= cmd.aot_escaped ? 7'd32 + {1'b0, shifted[5:0]} : {2'b00, shifted[4:0]};
      end
      if (cmd.set_ext) h_ext <= h_aot;
      if (cmd.set_sfi) h_sfi <= shifted[3:0];
      if (cmd.set_rate) h_rate <= shifted;
      if (cmd.set_ch) h_ch <= shifted[3:0];
      if (cmd.set_esfi) h_esfi <= shifted[3:0];
      if (cmd.set_dcc) gas_flags[0] <= shifted[0];
      if (cmd.set_extf) gas_flags[1] <= shifted[0];
      if (cmd.load_loop) loop_remaining <= cmd.loop_value;
      else if (cmd.dec_loop) loop_remaining <= loop_remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_count) element_counts[cmd.count_idx] <= shifted[3:0];
  end
endmodule

>>> hdl/ascp_ctrl.sv
// Syntax sequencer: walks the config syntax one bit per cycle while busy with a byte.
module ascp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_start,
  input  logic in_last,
  input  logic out_free,
  input  ascp_pkg::stat_t stat,
  output ascp_pkg::cmd_t cmd,
  output logic in_ready,
  output logic [2:0] bit_idx,
  output logic res_load,
  output logic res_status
);
  import ascp_pkg::*;

  phase_t phase, phase_next;
  phase_t phase_seq;
  logic busy, busy_next;
  logic last_q;
  logic [2:0] bit_next;

  logic run;
  logic [6:0] aot_new;
  logic is_gaext;

  assign run = busy;
  assign in_ready = !busy && out_free;

  // Work out the object type as written this cycle for decisions.
  always_comb begin
    aot_new = stat.aot;
    if (phase == PH_AOT2) aot_new = {2'b00, stat.value[4:0]};
    if (phase == PH_AOT2X) aot_new = 7'd32 + {1'b0, stat.value[5:0]};
  end
  assign is_gaext = (stat.aot == 7'd17) || (stat.aot == 7'd19) ||
                    (stat.aot == 7'd20) || (stat.aot == AotGaMax);

  // Next phase and datapath commands.
  always_comb begin
    phase_t np;
    logic [CntW-1:0] nl;
    logic ld;
    logic [2:0] k;
    logic found;
    logic [2:0] kk;
    logic [2:0] skip;
    np = phase;
    nl = '0;
    ld = 1'b0;
    k = '0;
    found = 1'b0;
    kk = '0;
    skip = '0;
    cmd = '0;
    if (run) begin
      cmd.shift_bit = 1'b1;
      if (stat.field_done) begin
        ld = 1'b1;
        unique case (phase)
          PH_AOT1: begin
            if (stat.value[4:0] == AotEscape) begin np = PH_AOT1X; nl = 5'd6; end
            else begin cmd.set_aot = 1'b1; np = PH_SFI; nl = 5'd4; end
          end
          PH_AOT1X: begin
            cmd.set_aot = 1'b1; cmd.aot_escaped = 1'b1; np = PH_SFI; nl = 5'd4;
          end
          PH_SFI: begin
            cmd.set_sfi = 1'b1;
            if (stat.value[3:0] == SfiExplicit) begin np = PH_RATE; nl = RateBits; end
            else begin np = PH_CH; nl = 5'd4; end
          end
          PH_RATE: begin cmd.set_rate = 1'b1; np = PH_CH; nl = 5'd4; end
          PH_CH: begin
            cmd.set_ch = 1'b1;
            if (stat.aot == AotSbr || stat.aot == AotPs) begin
              cmd.set_ext = 1'b1; np = PH_ESFI; nl = 5'd4;
            end else if (stat.aot >= 7'd1 && stat.aot <= AotGaMax) begin
              np = PH_FLF; nl = 5'd1;
            end else np = PH_DONE;
          end
          PH_ESFI: begin
            cmd.set_esfi = 1'b1;
            if (stat.value[3:0] == SfiExplicit) begin np = PH_ERATE; nl = RateBits; end
            else begin np = PH_AOT2; nl = 5'd5; end
          end
          PH_ERATE: begin np = PH_AOT2; nl = 5'd5; end
          PH_AOT2, PH_AOT2X: begin
            if (phase == PH_AOT2 && stat.value[4:0] == AotEscape) begin
              np = PH_AOT2X; nl = 5'd6;
            end else begin
              cmd.set_aot = 1'b1;
              cmd.aot_escaped = (phase == PH_AOT2X);
              if (aot_new == AotErBsac) begin np = PH_ECH; nl = 5'd4; end
              else if (aot_new >= 7'd1 && aot_new <= AotGaMax) begin
                np = PH_FLF; nl = 5'd1;
              end else np = PH_DONE;
            end
          end
          PH_ECH: begin
            if (stat.aot >= 7'd1 && stat.aot <= AotGaMax) begin np = PH_FLF; nl = 5'd1; end
            else np = PH_DONE;
          end
          PH_FLF: begin np = PH_DCC; nl = 5'd1; end
          PH_DCC: begin
            cmd.set_dcc = 1'b1;
            if (stat.value[0]) begin np = PH_DELAY; nl = DelayBits; end
            else begin np = PH_EXTF; nl = 5'd1; end
          end
          PH_DELAY: begin np = PH_EXTF; nl = 5'd1; end
          PH_EXTF: begin
            cmd.set_extf = 1'b1;
            if (stat.ch == 4'd0) begin np = PH_PCEHEAD; nl = 5'd10; end
            else np = PH_LAYER; // resolved below as after_pce
          end
          PH_PCEHEAD: begin np = PH_CNT0; nl = cnt_width(3'd0); end
          PH_CNT0, PH_CNT1, PH_CNT2, PH_CNT3, PH_CNT4, PH_CNT5: begin
            k = 3'(phase - PH_CNT0);
            cmd.set_count = 1'b1;
            cmd.count_idx = k;
            if (phase == PH_CNT5) begin np = PH_MONO; nl = 5'd1; end
            else begin np = phase_t'(phase + 6'd1); nl = cnt_width(k + 3'd1); end
          end
          PH_MONO: begin
            if (stat.value[0]) begin np = PH_MONON; nl = 5'd4; end
            else begin np = PH_STEREO; nl = 5'd1; end
          end
          PH_MONON: begin np = PH_STEREO; nl = 5'd1; end
          PH_STEREO: begin
            if (stat.value[0]) begin np = PH_STEREON; nl = 5'd4; end
            else begin np = PH_MATRIX; nl = 5'd1; end
          end
          PH_STEREON: begin np = PH_MATRIX; nl = 5'd1; end
          PH_MATRIX: begin
            if (stat.value[0]) begin np = PH_MATRIXV; nl = 5'd3; end
            else np = PH_EL0; // group search below
          end
          PH_MATRIXV: np = PH_EL0;
          PH_EL0, PH_EL1, PH_EL2, PH_EL3, PH_EL4, PH_EL5: begin
            k = 3'(phase - PH_EL0);
            cmd.dec_loop = 1'b1;
            if (stat.loop_left != 8'd1) begin np = phase; nl = el_width(k); end
          end
          PH_ALIGN: begin np = PH_CLEN; nl = 5'd8; end
          PH_CLEN: begin
            cmd.load_loop = 1'b1;
            cmd.loop_value = stat.value[7:0];
            if (stat.value[7:0] != 8'd0) begin np = PH_CBYTE; nl = 5'd8; end
            else np = PH_LAYER;
          end
          PH_CBYTE: begin
            cmd.dec_loop = 1'b1;
            if (stat.loop_left != 8'd1) begin np = PH_CBYTE; nl = 5'd8; end
            else np = PH_LAYER;
          end
          PH_LAYER: np = PH_SUBF;
          PH_SUBF: begin
            if (is_gaext) begin np = PH_RES; nl = 5'd3; end
            else begin np = PH_EXT3; nl = 5'd1; end
          end
          PH_RES: begin np = PH_EXT3; nl = 5'd1; end
          default: np = PH_DONE;
        endcase

        // Group search after the matrix fields or a finished element loop.
        if ((phase == PH_MATRIX && !stat.value[0]) || phase == PH_MATRIXV ||
            ((phase >= PH_EL0 && phase <= PH_EL5) && stat.loop_left == 8'd1)) begin
          kk = (phase >= PH_EL0 && phase <= PH_EL5) ? 3'(phase - PH_EL0) + 3'd1 : 3'd0;
          for (int j = 0; j < NumGroups; j++) begin
            if (!found && 3'(j) >= kk && stat.count_nz[j]) begin
              found = 1'b1;
              np = phase_t'(PH_EL0 + 6'(j));
              nl = el_width(3'(j));
              cmd.load_loop = 1'b1;
              cmd.loop_value = {4'd0, stat.counts[j]};
            end
          end
          if (!found) begin
            skip = 3'd0 - stat.bit_pos;
            if (skip != 3'd0) begin np = PH_ALIGN; nl = {2'b00, skip}; end
            else begin np = PH_CLEN; nl = 5'd8; end
          end
        end

        // after_pce: from EXTF without PCE, end of comment, or zero length.
        if ((phase == PH_EXTF && stat.ch != 4'd0) ||
            (phase == PH_CLEN && stat.value[7:0] == 8'd0) ||
            (phase == PH_CBYTE && stat.loop_left == 8'd1)) begin
          if (stat.aot == 7'd6 || stat.aot == 7'd20) begin np = PH_LAYER; nl = 5'd3; end
          else np = PH_EXT3;  // after_layer below
        end
        // after_layer
        if (np == PH_EXT3 && phase != PH_SUBF && phase != PH_RES || phase == PH_LAYER) begin
          if (!((phase == PH_EXTF && stat.ch == 4'd0))) begin
            if (!(phase == PH_EXTF ? stat.value[0] : stat.extf)) np = PH_DONE;
            else if (stat.aot == AotErBsac) begin np = PH_SUBF; nl = 5'd16; end
            else if (is_gaext) begin np = PH_RES; nl = 5'd3; end
            else begin np = PH_EXT3; nl = 5'd1; end
          end
        end
      end
    end
    cmd.load_field = ld;
    cmd.field_len = nl;
    if (in_fire && in_start) begin
      cmd = '0;
      cmd.clear = 1'b1;
      cmd.field_len = 5'd5;
    end
    phase_seq = np;
  end

  // Byte-level sequencing and result hand-off.
  always_comb begin
    phase_next = phase_seq;
    busy_next = busy;
    bit_next = bit_idx;
    res_load = 1'b0;
    res_status = 1'b0;
    if (in_fire) begin
      if (in_start) phase_next = PH_AOT1;
      bit_next = 3'd0;
      busy_next = in_start || (phase != PH_IDLE && phase != PH_DONE);
    end else if (busy) begin
      bit_next = bit_idx + 3'd1;
      if (phase_next == PH_DONE) begin
        busy_next = 1'b0;
        res_load = 1'b1;
      end else if (bit_idx == 3'd7) begin
        busy_next = 1'b0;
        if (last_q) begin
          res_load = 1'b1;
          res_status = 1'b1;
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      busy <= 1'b0;
      bit_idx <= '0;
      last_q <= 1'b0;
    end else begin
      phase <= phase_next;
      busy <= busy_next;
      bit_idx <= bit_next;
      if (in_fire) last_q <= in_last;
    end
  end
endmodule

>>> hdl/audio_specific_config_parser_core.sv
// Top level of the audio config parser: controller, datapath and output register.
// A byte accepted is worked through one bit per cycle; a result is registered in the
// pending register and then the output register after the bit that completes the
// syntax, or after the eighth bit of a byte marked last. A new byte is taken only once
// the last one is worked through and no result is held. Synchronous active-high reset
// returns the parser to idle, awaiting a byte marked start, with no result pending.
module audio_specific_config_parser_core (
  input logic clk,
  input logic rst,
  ascp_in_if.sink in_ch,
  ascp_out_if.source out_ch
);
  import ascp_pkg::*;
`include "assert_macros.svh"

  cmd_t cmd;
  stat_t stat;
  logic [7:0] byte_reg;
  logic [2:0] bit_idx;
  logic in_fire;
  logic res_load;
  logic res_status;
  logic out_valid;
  logic in_ready;
  logic [6:0] h_aot, h_ext;
  logic [3:0] h_sfi, h_esfi, h_ch;
  logic [23:0] h_rate;
  logic res_pend;
  logic res_stat_q;

  // The input beat is taken only when the sequencer is idle and the pending and output
  // registers are empty, so a result never overwrites one still waiting.
  assign in_fire = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) byte_reg <= in_ch.data_byte;
  end

  ascp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_start(in_ch.start_req),
    .in_last(in_ch.last_byte), .out_free(!out_valid && !res_pend), .stat(stat), .cmd(cmd),
    .in_ready(in_ready), .bit_idx(bit_idx), .res_load(res_load), .res_status(res_status)
  );

  ascp_datapath u_dp (
    .clk(clk), .rst(rst), .byte_reg(byte_reg), .bit_idx(bit_idx), .cmd(cmd), .stat(stat),
    .h_aot(h_aot), .h_ext(h_ext), .h_sfi(h_sfi), .h_rate(h_rate), .h_esfi(h_esfi), .h_ch(h_ch)
  );

  // Result register. Field writes of the finishing bit land in the same edge,
  // so the fields are sampled in the following cycle from the held registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_pend <= 1'b0;
    end else begin
      res_pend <= res_load;
      if (res_load) res_stat_q <= res_status;
      if (res_pend) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_pend) begin
      out_ch.status <= res_stat_q;
      out_ch.core_aot <= h_aot;
      out_ch.extension_type <= h_ext;
      out_ch.sampling_index <= h_sfi;
      out_ch.sampling_rate <= h_rate;
      out_ch.ext_sampling_index <= h_esfi;
      out_ch.channel_config <= h_ch;
    end
  end

  assign out_ch.valid = out_valid;

  // A new beat is never taken while a result is pending or waiting.
  `ASSERT_IMPL(a_no_accept_while_full, clk, rst, in_fire, !out_valid && !res_pend,
               "input beat accepted while a result is held")
  // A pending result always reaches the output register.
  `ASSERT_NEXT(a_pend_to_valid, clk, rst, res_pend, out_valid,
               "pending result did not reach the output register")
  // Results are never loaded on consecutive cycles.
  `ASSERT_NEXT(a_single_load, clk, rst, res_load, !res_load,
               "two results loaded back to back")
endmodule
